// ----- src/sbfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbfc_pkg: shared types and constants for the segment/box face clipper
// Coordinate widths, product and sum widths, hit axis codes and the
// face test order (Y, X, Z) with the two cross axes of each face.
// ----------------------------------------------------------------------------
package sbfc_pkg;

  // Axis count and field widths
  localparam int unsigned NumAxes = 3;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned HalfW   = 30;

  // Crossing numerator / denominator widths
  localparam int unsigned FaceW   = CoordW + 2;   // c +/- h
  localparam int unsigned NumW    = CoordW + 3;   // face - p
  localparam int unsigned NW      = CoordW + 4;   // signed numerator, room for negate
  localparam int unsigned DiffW   = CoordW + 1;   // p - c

  // Exact product widths
  localparam int unsigned TmW     = 2 * CoordW + 1;   // m * n
  localparam int unsigned PcdW    = 2 * DiffW;        // (p - c) * d
  localparam int unsigned HdW     = HalfW + CoordW;   // h * d
  localparam int unsigned SumW    = 68;               // bounds are all well inside

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [HalfW-1:0]  half_t;
  typedef logic        [1:0]        axis_t;

  // Hit axis codes as seen on the result port
  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_X    = 2'd2,
    AXIS_Z    = 2'd3
  } hit_axis_e;

  // Axis indexes
  localparam axis_t IdxX = 2'd0;
  localparam axis_t IdxY = 2'd1;
  localparam axis_t IdxZ = 2'd2;

  // Face slot in priority order: slot 0 is Y, slot 1 is X, slot 2 is Z
  function automatic axis_t face_axis(input int unsigned slot);
    axis_t r;
    case (slot)
      0: r = IdxY;
      1: r = IdxX;
      default: r = IdxZ;
    endcase
    return r;
  endfunction

  // The two cross axes checked for a face slot
  function automatic axis_t other_axis(input int unsigned slot, input int unsigned k);
    axis_t r;
    case (slot)
      0: r = (k == 0) ? IdxX : IdxZ;
      1: r = (k == 0) ? IdxY : IdxZ;
      default: r = (k == 0) ? IdxY : IdxX;
    endcase
    return r;
  endfunction

endpackage

// ----- src/segment_box_face_clip.sv -----
// Each accepted request passes through all five register stages; done_o marks its result.
// Throughput: one request per cycle, every cycle; busy_o is always low.
// Five register stages: crossing setup, exact multiplies, partial sum, face
// compares, priority select. The receiver cannot stall, so nothing holds back.
// Reset clears only the valid bits of the stages; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_box_face_clip: clip a planned move against an axis-aligned box
// Tests the Y, X, Z faces in order with exact cross-multiplied compares and
// zeroes the move component of the first face crossed.
// ----------------------------------------------------------------------------
module segment_box_face_clip (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  sbfc_pkg::coord_t       pos_x_i,
  input  sbfc_pkg::coord_t       pos_y_i,
  input  sbfc_pkg::coord_t       pos_z_i,
  input  sbfc_pkg::coord_t       move_x_i,
  input  sbfc_pkg::coord_t       move_y_i,
  input  sbfc_pkg::coord_t       move_z_i,
  input  sbfc_pkg::coord_t       box_x_i,
  input  sbfc_pkg::coord_t       box_y_i,
  input  sbfc_pkg::coord_t       box_z_i,
  input  sbfc_pkg::half_t        half_x_i,
  input  sbfc_pkg::half_t        half_y_i,
  input  sbfc_pkg::half_t        half_z_i,
  output logic                   done_o,
  output sbfc_pkg::coord_t       out_move_x_o,
  output sbfc_pkg::coord_t       out_move_y_o,
  output sbfc_pkg::coord_t       out_move_z_o,
  output logic                   hit_o,
  output logic [1:0]             hit_axis_o
);

  localparam int unsigned NA = sbfc_pkg::NumAxes;
  localparam int unsigned CW = sbfc_pkg::CoordW;
  localparam int unsigned HW = sbfc_pkg::HalfW;

  // Request fields as per-axis arrays
  sbfc_pkg::coord_t pos  [NA];
  sbfc_pkg::coord_t mov  [NA];
  sbfc_pkg::coord_t box  [NA];
  sbfc_pkg::half_t  half [NA];

  assign pos[0]  = pos_x_i;
  assign pos[1]  = pos_y_i;
  assign pos[2]  = pos_z_i;
  assign mov[0]  = move_x_i;
  assign mov[1]  = move_y_i;
  assign mov[2]  = move_z_i;
  assign box[0]  = box_x_i;
  assign box[1]  = box_y_i;
  assign box[2]  = box_z_i;
  assign half[0] = half_x_i;
  assign half[1] = half_y_i;
  assign half[2] = half_z_i;

  // Fully pipelined, never stalls
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: crossing numerator n, denominator d = |m|, 0 < n < d check
  // --------------------------------------------------------------------------
  logic signed [sbfc_pkg::FaceW-1:0] face_w [NA];
  logic signed [sbfc_pkg::NumW-1:0]  num_w  [NA];
  logic signed [sbfc_pkg::NW-1:0]    n_w    [NA];
  logic        [CW-1:0]              d_w    [NA];
  logic                              ok_w   [NA];
  logic signed [sbfc_pkg::DiffW-1:0] pc_w   [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      // approached face: c + h for a negative move, c - h for a positive one
      face_w[a] = mov[a][CW-1]
                ? ({{2{box[a][CW-1]}}, box[a]} + {4'b0, half[a]})
                : ({{2{box[a][CW-1]}}, box[a]} - {4'b0, half[a]});
      num_w[a]  = {face_w[a][sbfc_pkg::FaceW-1], face_w[a]}
                - {{3{pos[a][CW-1]}}, pos[a]};
      n_w[a]    = mov[a][CW-1] ? -{num_w[a][sbfc_pkg::NumW-1], num_w[a]}
                               :  {num_w[a][sbfc_pkg::NumW-1], num_w[a]};
      d_w[a]    = mov[a][CW-1] ? (~mov[a] + 1'b1) : mov[a];
      ok_w[a]   = (mov[a] != '0) && !n_w[a][sbfc_pkg::NW-1] && (n_w[a] != '0)
               && (n_w[a] < $signed({4'b0, d_w[a]}));
      pc_w[a]   = {pos[a][CW-1], pos[a]} - {box[a][CW-1], box[a]};
    end
  end

  logic                              v1_q;
  logic        [CW-1:0]              n1_q   [NA];
  logic        [CW-1:0]              d1_q   [NA];
  logic                              ok1_q  [NA];
  logic signed [sbfc_pkg::DiffW-1:0] pc1_q  [NA];
  sbfc_pkg::half_t                   h1_q   [NA];
  sbfc_pkg::coord_t                  m1_q   [NA];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      n1_q[a]  <= n_w[a][CW-1:0];
      d1_q[a]  <= d_w[a];
      ok1_q[a] <= ok_w[a];
      pc1_q[a] <= pc_w[a];
      h1_q[a]  <= half[a];
      m1_q[a]  <= mov[a];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact products for each face slot and each cross axis
  //   tm = m[b] * n, pcd = (p[b] - c[b]) * d, hd = h[b] * d
  // --------------------------------------------------------------------------
  logic signed [sbfc_pkg::TmW-1:0]  tm_w  [NA][2];
  logic signed [sbfc_pkg::PcdW-1:0] pcd_w [NA][2];
  logic        [sbfc_pkg::HdW-1:0]  hd_w  [NA][2];

  for (genvar s = 0; s < NA; s++) begin : g_slot
    localparam sbfc_pkg::axis_t FA = sbfc_pkg::face_axis(s);
    for (genvar k = 0; k < 2; k++) begin : g_cross
      localparam sbfc_pkg::axis_t OB = sbfc_pkg::other_axis(s, k);
      assign tm_w[s][k]  = $signed({{(CW+1){m1_q[OB][CW-1]}}, m1_q[OB]})
                         * $signed({(CW+1)'(0), n1_q[FA]});
      assign pcd_w[s][k] = $signed({{CW{pc1_q[OB][sbfc_pkg::DiffW-1]}}, pc1_q[OB]})
                         * $signed({(CW+2)'(0), d1_q[FA]});
      assign hd_w[s][k]  = {(CW)'(0), h1_q[OB]} * {(HW)'(0), d1_q[FA]};
    end
  end

  logic                              v2_q;
  logic                              ok2_q  [NA];
  sbfc_pkg::coord_t                  m2_q   [NA];
  logic signed [sbfc_pkg::TmW-1:0]   tm2_q  [NA][2];
  logic signed [sbfc_pkg::PcdW-1:0]  pcd2_q [NA][2];
  logic        [sbfc_pkg::HdW-1:0]   hd2_q  [NA][2];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NA; s++) begin
      ok2_q[s] <= ok1_q[s];
      m2_q[s]  <= m1_q[s];
      for (int k = 0; k < 2; k++) begin
        tm2_q[s][k]  <= tm_w[s][k];
        pcd2_q[s][k] <= pcd_w[s][k];
        hd2_q[s][k]  <= hd_w[s][k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: shared part of both bounds, base = (p - c) * d + m * n
  // --------------------------------------------------------------------------
  localparam int unsigned SW = sbfc_pkg::SumW;

  logic                              v3_q;
  logic                              ok3_q  [NA];
  sbfc_pkg::coord_t                  m3_q   [NA];
  logic signed [SW-1:0]              base3_q[NA][2];
  logic        [sbfc_pkg::HdW-1:0]   hd3_q  [NA][2];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NA; s++) begin
      ok3_q[s] <= ok2_q[s];
      m3_q[s]  <= m2_q[s];
      for (int k = 0; k < 2; k++) begin
        base3_q[s][k] <= {{(SW-sbfc_pkg::PcdW){pcd2_q[s][k][sbfc_pkg::PcdW-1]}},
                          pcd2_q[s][k]}
                       + {{(SW-sbfc_pkg::TmW){tm2_q[s][k][sbfc_pkg::TmW-1]}},
                          tm2_q[s][k]};
        hd3_q[s][k]   <= hd2_q[s][k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: strict interval test on both cross axes, face pass flags
  //   lo = base + h*d must be > 0, hi = base - h*d must be < 0
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] lo_w     [NA][2];
  logic signed [SW-1:0] hi_w     [NA][2];
  logic                 inside_w [NA][2];
  logic                 pass_w   [NA];

  always_comb begin
    for (int s = 0; s < NA; s++) begin
      for (int k = 0; k < 2; k++) begin
        lo_w[s][k]     = base3_q[s][k] + $signed({(SW-sbfc_pkg::HdW)'(0), hd3_q[s][k]});
        hi_w[s][k]     = base3_q[s][k] - $signed({(SW-sbfc_pkg::HdW)'(0), hd3_q[s][k]});
        inside_w[s][k] = !lo_w[s][k][SW-1] && (lo_w[s][k] != '0) && hi_w[s][k][SW-1];
      end
      pass_w[s] = ok3_q[sbfc_pkg::face_axis(s)] && inside_w[s][0] && inside_w[s][1];
    end
  end

  logic             v4_q;
  logic             pass4_q [NA];
  sbfc_pkg::coord_t m4_q    [NA];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NA; s++) begin
      pass4_q[s] <= pass_w[s];
      m4_q[s]    <= m3_q[s];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: first passing face in Y, X, Z order; zero that move component
  // --------------------------------------------------------------------------
  sbfc_pkg::hit_axis_e hit_axis_d;
  sbfc_pkg::coord_t    mx_d, my_d, mz_d;

  always_comb begin
    mx_d = m4_q[sbfc_pkg::IdxX];
    my_d = m4_q[sbfc_pkg::IdxY];
    mz_d = m4_q[sbfc_pkg::IdxZ];
    if (pass4_q[0]) begin
      hit_axis_d = sbfc_pkg::AXIS_Y;
      my_d       = '0;
    end else if (pass4_q[1]) begin
      hit_axis_d = sbfc_pkg::AXIS_X;
      mx_d       = '0;
    end else if (pass4_q[2]) begin
      hit_axis_d = sbfc_pkg::AXIS_Z;
      mz_d       = '0;
    end else begin
      hit_axis_d = sbfc_pkg::AXIS_NONE;
    end
  end

  logic                done_q;
  sbfc_pkg::coord_t    mx_q, my_q, mz_q;
  logic                hit_q;
  sbfc_pkg::hit_axis_e hit_axis_q;

  always_ff @(posedge clk_i) begin
    mx_q       <= mx_d;
    my_q       <= my_d;
    mz_q       <= mz_d;
    hit_q      <= (hit_axis_d != sbfc_pkg::AXIS_NONE);
    hit_axis_q <= hit_axis_d;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  assign done_o       = done_q;
  assign out_move_x_o = mx_q;
  assign out_move_y_o = my_q;
  assign out_move_z_o = mz_q;
  assign hit_o        = hit_q;
  assign hit_axis_o   = hit_axis_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every request started is followed by its done_o strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o)
    else $error("request did not complete after five cycles");

  // the hit flag agrees with the reported face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (hit_axis_o != sbfc_pkg::AXIS_NONE)))
    else $error("hit flag and hit axis disagree");

  // a reported Y face has its move y component cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_axis_o == sbfc_pkg::AXIS_Y) |-> (out_move_y_o == '0))
    else $error("y face hit but move y not cleared");

  // without a hit the move passes through untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (out_move_x_o == $past(move_x_i, 5)
                         && out_move_y_o == $past(move_y_i, 5)
                         && out_move_z_o == $past(move_z_i, 5)))
    else $error("move changed without a hit");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the segment/box face clipper
// Drives collision requests through the start/busy handshake and checks
// every done_o strobe against an exact, wide-integer model of the Y, X, Z
// face tests. A short table of hand-picked requests comes first: simple
// hits, exact touches, empty intervals and field extremes. Seeded random
// traffic follows, mostly segments aimed into a box, under several pacing
// phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               U            = 65536;   // 1.0 in Q16.16
  localparam sbfc_pkg::coord_t CMIN         = 32'sh8000_0000;
  localparam sbfc_pkg::coord_t CMAX         = 32'sh7FFF_FFFF;
  localparam sbfc_pkg::half_t  HMAX         = 30'h3FFF_FFFF;
  localparam int               RandPerPhase = 440;
  localparam int               DrainCycles  = 12;      // pipeline depth plus margin
  localparam int               CycleLimit   = 150000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    sbfc_pkg::coord_t pos_x, pos_y, pos_z;
    sbfc_pkg::coord_t move_x, move_y, move_z;
    sbfc_pkg::coord_t box_x, box_y, box_z;
    sbfc_pkg::half_t  half_x, half_y, half_z;
  } clip_req_t;

  typedef struct packed {
    sbfc_pkg::coord_t    mx, my, mz;
    logic                hit;
    sbfc_pkg::hit_axis_e axis;
  } clip_res_t;

  typedef struct {
    clip_req_t req;
    bit        typed;
    clip_res_t want;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             done_o;
  sbfc_pkg::coord_t out_move_x_o, out_move_y_o, out_move_z_o;
  logic             hit_o;
  logic [1:0]       hit_axis_o;

  clip_req_t drv;
  bit        cur_known;
  clip_res_t cur_want;
  clip_res_t pending_clips[$];
  row_t      plan[$];

  int mismatches = 0;
  int clips_y = 0, clips_x = 0, clips_z = 0, pass_through = 0;
  int cycles = 0;
  int random_sent = 0;

  segment_box_face_clip DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pos_x_i      (drv.pos_x),
    .pos_y_i      (drv.pos_y),
    .pos_z_i      (drv.pos_z),
    .move_x_i     (drv.move_x),
    .move_y_i     (drv.move_y),
    .move_z_i     (drv.move_z),
    .box_x_i      (drv.box_x),
    .box_y_i      (drv.box_y),
    .box_z_i      (drv.box_z),
    .half_x_i     (drv.half_x),
    .half_y_i     (drv.half_y),
    .half_z_i     (drv.half_z),
    .done_o       (done_o),
    .out_move_x_o (out_move_x_o),
    .out_move_y_o (out_move_y_o),
    .out_move_z_o (out_move_z_o),
    .hit_o        (hit_o),
    .hit_axis_o   (hit_axis_o)
  );

  // --------------------------------------------------------------------------
  // Exact face model
  // --------------------------------------------------------------------------

  // Crossing at t = n/d lies strictly inside (c-h, c+h) on a cross axis
  function automatic bit strictly_inside(wide_t p, wide_t mv, wide_t c, wide_t h,
                                         wide_t n, wide_t d);
    wide_t tm, lo_side, hi_side;
    tm      = mv * n;
    lo_side = (p - (c - h)) * d + tm;
    hi_side = (p - (c + h)) * d + tm;
    return (lo_side > 0) && (hi_side < 0);
  endfunction

  // Face axis a, cross axes b and e
  function automatic bit face_crossed(wide_t pa, wide_t ma, wide_t ca, wide_t ha,
                                      wide_t pb, wide_t mb, wide_t cb, wide_t hb,
                                      wide_t pe, wide_t me, wide_t ce, wide_t he);
    wide_t face, n, d;
    if (ma == 0) return 1'b0;
    face = (ma < 0) ? ca + ha : ca - ha;
    n    = (ma > 0) ? face - pa : pa - face;
    d    = (ma > 0) ? ma : -ma;
    if (!(n > 0 && n < d)) return 1'b0;
    return strictly_inside(pb, mb, cb, hb, n, d) && strictly_inside(pe, me, ce, he, n, d);
  endfunction

  function automatic clip_res_t clip_move(clip_req_t r);
    wide_t px, py, pz, mx, my, mz, cx, cy, cz, hx, hy, hz;
    clip_res_t res;
    px = $signed(r.pos_x);  py = $signed(r.pos_y);  pz = $signed(r.pos_z);
    mx = $signed(r.move_x); my = $signed(r.move_y); mz = $signed(r.move_z);
    cx = $signed(r.box_x);  cy = $signed(r.box_y);  cz = $signed(r.box_z);
    hx = r.half_x;          hy = r.half_y;          hz = r.half_z;
    res.mx   = r.move_x;
    res.my   = r.move_y;
    res.mz   = r.move_z;
    res.hit  = 1'b1;
    res.axis = sbfc_pkg::AXIS_NONE;
    // priority Y, X, Z
    if (face_crossed(py, my, cy, hy, px, mx, cx, hx, pz, mz, cz, hz)) begin
      res.axis = sbfc_pkg::AXIS_Y;
      res.my   = '0;
    end else if (face_crossed(px, mx, cx, hx, py, my, cy, hy, pz, mz, cz, hz)) begin
      res.axis = sbfc_pkg::AXIS_X;
      res.mx   = '0;
    end else if (face_crossed(pz, mz, cz, hz, py, my, cy, hy, px, mx, cx, hx)) begin
      res.axis = sbfc_pkg::AXIS_Z;
      res.mz   = '0;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic clip_req_t req_of(
    sbfc_pkg::coord_t px, sbfc_pkg::coord_t py, sbfc_pkg::coord_t pz,
    sbfc_pkg::coord_t mx, sbfc_pkg::coord_t my, sbfc_pkg::coord_t mz,
    sbfc_pkg::coord_t cx, sbfc_pkg::coord_t cy, sbfc_pkg::coord_t cz,
    sbfc_pkg::half_t hx, sbfc_pkg::half_t hy, sbfc_pkg::half_t hz);
    clip_req_t r;
    r = '{px, py, pz, mx, my, mz, cx, cy, cz, hx, hy, hz};
    return r;
  endfunction

  function automatic clip_res_t res_of(sbfc_pkg::coord_t mx, sbfc_pkg::coord_t my,
                                       sbfc_pkg::coord_t mz, sbfc_pkg::hit_axis_e ax);
    clip_res_t r;
    r = '{mx, my, mz, ax != sbfc_pkg::AXIS_NONE, ax};
    return r;
  endfunction

  task automatic add_row(clip_req_t r, bit typed, clip_res_t w);
    row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = w;
    plan.insert(plan.size(), row);
  endtask

  // Signed value in [-2^bits, 2^bits)
  function automatic int signed_span(int bits);
    return int'($urandom) >>> (31 - bits);
  endfunction

  function automatic sbfc_pkg::coord_t edge_coord();
    sbfc_pkg::coord_t v;
    case ($urandom_range(0, 5))
      0: v = CMIN;
      1: v = CMAX;
      2: v = '0;
      3: v = -1;
      4: v = 1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic sbfc_pkg::half_t edge_half();
    sbfc_pkg::half_t v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = HMAX;
      2: v = 1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Segment whose point at t = k/8 lies inside the box; with touch set,
  // that point sits on a face or an edge and t may be exactly 0 or 1
  function automatic clip_req_t aimed_req(bit touch);
    int c[3], h[3], m[3], t[3], p[3];
    int sc, k, a;
    clip_req_t r;
    sc = $urandom_range(6, 27);
    for (int i = 0; i < 3; i++) begin
      c[i] = signed_span(sc);
      h[i] = $urandom_range(1, 1 << (sc - 1));
      m[i] = ($urandom_range(0, 3) == 0) ? 0 : signed_span(sc + 1);
      if (touch) m[i] = m[i] & ~7;
      t[i] = c[i] + int'($urandom_range(0, 2 * h[i] - 2)) - (h[i] - 1);
    end
    if (touch) begin
      k = $urandom_range(0, 8);
      a = $urandom_range(0, 2);
      for (int j = 0; j < 2; j++) begin
        if (j == 0 || $urandom_range(0, 1) == 1) begin
          if (m[a] > 0) t[a] = c[a] - h[a];
          else if (m[a] < 0) t[a] = c[a] + h[a];
          else t[a] = $urandom_range(0, 1) ? c[a] + h[a] : c[a] - h[a];
        end
        a = (a + 1) % 3;
      end
    end else begin
      k = $urandom_range(1, 7);
    end
    for (int i = 0; i < 3; i++) p[i] = t[i] - (m[i] * k) / 8;
    r = req_of(p[0], p[1], p[2], m[0], m[1], m[2], c[0], c[1], c[2], h[0], h[1], h[2]);
    return r;
  endfunction

  function automatic clip_req_t random_req();
    clip_req_t r;
    case ($urandom_range(0, 9))
      5: r = aimed_req(1'b1);
      6: begin
        // raw noise, every bit free
        r = req_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      7: begin
        // tiny integer grid, lots of exact ties
        r = req_of(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                   int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                   int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                   int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2,
                   int'($urandom_range(0, 4)) - 2, $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 3));
      end
      8: begin
        r = req_of(edge_coord(), edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                   edge_coord(), edge_coord(), edge_coord(), edge_coord(), edge_half(),
                   edge_half(), edge_half());
      end
      default: r = aimed_req(1'b0);
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("segment_box_face_clip test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker; also records each accepted request's expected result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    clip_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_clips.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          want = pending_clips.pop_front();
          if (out_move_x_o !== want.mx) begin
            $error("out_move_x: expected %0d, got %0d", want.mx, out_move_x_o);
            mismatches++;
          end
          if (out_move_y_o !== want.my) begin
            $error("out_move_y: expected %0d, got %0d", want.my, out_move_y_o);
            mismatches++;
          end
          if (out_move_z_o !== want.mz) begin
            $error("out_move_z: expected %0d, got %0d", want.mz, out_move_z_o);
            mismatches++;
          end
          if (hit_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_o);
            mismatches++;
          end
          if (hit_axis_o !== want.axis) begin
            $error("hit_axis: expected %0d, got %0d", want.axis, hit_axis_o);
            mismatches++;
          end
          case (want.axis)
            sbfc_pkg::AXIS_Y: clips_y++;
            sbfc_pkg::AXIS_X: clips_x++;
            sbfc_pkg::AXIS_Z: clips_z++;
            default:          pass_through++;
          endcase
        end
      end
      if (start_i && !busy_o) begin
        pending_clips.insert(pending_clips.size(), cur_known ? cur_want : clip_move(drv));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_clip(clip_req_t r, bit typed, clip_res_t w, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    drv       <= r;
    cur_known <= typed;
    cur_want  <= w;
    start_i   <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  initial begin
    int sender_idle_pct[4];
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    drv       = '0;
    cur_known = 1'b0;
    cur_want  = '0;
    // receiver cannot stall, so its stall phase runs with a busy sender
    sender_idle_pct = '{0, 69, 0, 38};

    // hand-picked requests after an all-zero one, box at the origin with unit half-sizes unless noted
    add_row(req_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_NONE));
    add_row(req_of(0, -2*U, 0, U/2, 2*U, U/4, 0, 0, 0, U, U, U), 1,
            res_of(U/2, 0, U/4, sbfc_pkg::AXIS_Y));
    add_row(req_of(0, 2*U, 0, 0, -2*U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_Y));
    add_row(req_of(-2*U, 0, 0, 2*U, 0, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_X));
    add_row(req_of(2*U, U/2, 0, -2*U, -U/2, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, -U/2, 0, sbfc_pkg::AXIS_X));
    add_row(req_of(0, 0, 2*U, 0, 0, -2*U, 0, 0, 0, U, U, U), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_Z));
    add_row(req_of(U/4, 0, -3*U, 0, 0, 4*U, 0, 0, 0, U, U, U), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_Z));
    // touching at t = 1 and t = 0
    add_row(req_of(0, -2*U, 0, 0, U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, U, 0, sbfc_pkg::AXIS_NONE));
    add_row(req_of(0, -U, 0, 0, U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, U, 0, sbfc_pkg::AXIS_NONE));
    // crossing point exactly on an edge of the face
    add_row(req_of(-U, -2*U, 0, 0, 2*U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 2*U, 0, sbfc_pkg::AXIS_NONE));
    add_row(req_of(0, -2*U, U, 0, 2*U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 2*U, 0, sbfc_pkg::AXIS_NONE));
    // zero half-size on a cross axis, then on the face axis
    add_row(req_of(0, -2*U, 0, 0, 2*U, 0, 0, 0, 0, 0, U, U), 1,
            res_of(0, 2*U, 0, sbfc_pkg::AXIS_NONE));
    add_row(req_of(0, -2*U, 0, 0, 4*U, 0, 0, 0, 0, U, 0, U), 0, '0);
    // clean miss, start inside, diagonal, no move at all
    add_row(req_of(5*U, -2*U, 0, 0, 2*U, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 2*U, 0, sbfc_pkg::AXIS_NONE));
    add_row(req_of(0, 0, 0, 2*U, 2*U, 2*U, 0, 0, 0, U, U, U), 0, '0);
    add_row(req_of(-2*U, -2*U, -2*U, 3*U, 3*U, 3*U, 0, 0, 0, U, U, U), 0, '0);
    add_row(req_of(U/2, U/2, 0, 0, 0, 0, 0, 0, 0, U, U, U), 1,
            res_of(0, 0, 0, sbfc_pkg::AXIS_NONE));
    // field extremes
    add_row(req_of(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, HMAX, HMAX, HMAX),
            0, '0);
    add_row(req_of(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX),
            0, '0);
    add_row(req_of(0, 0, 0, CMIN, CMIN, CMIN, 0, 0, 0, HMAX, HMAX, HMAX), 0, '0);
    add_row(req_of(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, HMAX, HMAX, HMAX), 0, '0);
    add_row(req_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, HMAX, HMAX, HMAX), 0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_clip(plan[i].req, plan[i].typed, plan[i].want, 0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RandPerPhase; n++) begin
        send_clip(random_req(), 1'b0, '0, sender_idle_pct[ph]);
        random_sent++;
      end
    end
    start_i <= 1'b0;

    while (pending_clips.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d table rows and %0d random requests over four pacing phases.",
             plan.size(), random_sent);
    $display("Clipped on y %0d, x %0d, z %0d times; %0d moves passed unchanged.",
             clips_y, clips_x, clips_z, pass_through);
    if (mismatches == 0) begin
      $display("segment_box_face_clip test passed");
    end else begin
      $display("segment_box_face_clip test failed");
    end
    $finish;
  end

endmodule

// ----- segment_box_face_clip.f -----
src/sbfc_pkg.sv
src/segment_box_face_clip.sv
test/testbench.sv
